FILE: hw/rtl/bvte_pkg.sv
// Shared types and constants for the bounded vector table engine.
package bvte_pkg;

   localparam int WORD_W      = 32;
   localparam int POS_W       = 8;
   localparam int FOUND_W     = 8;
   localparam int FILL_OUT_W  = 9;
   localparam int EXT_W       = 17;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   typedef enum logic [2:0] {
      CMD_INIT   = 3'd0,
      CMD_PUSH   = 3'd1,
      CMD_GET    = 3'd2,
      CMD_SET    = 3'd3,
      CMD_NEXT   = 3'd4,
      CMD_FIND   = 3'd5,
      CMD_SUM    = 3'd6,
      CMD_REWIND = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      BK_IDLE = 2'd0,
      BK_READ = 2'd1,
      BK_SCAN = 2'd2
   } back_state_type;

   typedef struct packed {
      cmd_type                   cmd;
      logic [POS_W-1:0]          pos;
      logic signed [WORD_W-1:0]  word;
   } req_item_type;

   typedef struct packed {
      logic         valid;
      req_item_type item;
   } queue_head_type;

endpackage

FILE: hw/rtl/bvte_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module bvte_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/bvte_front.sv
// Front end: accepts command transactions and holds them in a short queue.
module bvte_front
   import bvte_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [2:0]                req_command,
   input  logic [POS_W-1:0]          req_position,
   input  logic signed [WORD_W-1:0]  req_word,
   output queue_head_type            head,
   input  logic                      pop
);

   req_item_type      slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              accept;
   req_item_type      item_in;

   assign busy         = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign accept       = start && !busy;
   assign item_in.cmd  = cmd_type'(req_command);
   assign item_in.pos  = req_position;
   assign item_in.word = req_word;
   assign head.valid   = (count_ff != '0);
   assign head.item    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = accept ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (accept && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !accept) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         slot_ff[wr_ptr_ff] <= item_in;
      end
   end

`ifndef SYNTHESIS
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("queue popped while empty");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");
`endif

endmodule

FILE: hw/rtl/bvte_back.sv
// Back end: executes queued commands against the entry store and forms results.
module bvte_back
   import bvte_pkg::*;
#(
   parameter int CAPACITY = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  queue_head_type                  head,
   output logic                            pop,
   output logic                            rsp_strobe,
   output logic signed [WORD_W-1:0]        rsp_read_word,
   output logic [FOUND_W-1:0]              rsp_found_at,
   output logic [1:0]                      rsp_status,
   output logic [FILL_OUT_W-1:0]           rsp_fill
);

   localparam int AW = $clog2(CAPACITY);
   localparam int FW = $clog2(CAPACITY + 1);
   localparam logic [FW-1:0] CAP_F = FW'(CAPACITY);

   back_state_type           state_ff, state_in;
   logic [FW-1:0]            fill_ff, fill_in;
   logic [FW-1:0]            cursor_ff, cursor_in;
   logic                     e0_valid_ff, e0_valid_in;
   cmd_type                  op_ff, op_in;
   logic [WORD_W-1:0]        key_ff, key_in;
   logic [FW-1:0]            issue_ff, issue_in;
   logic                     pend_ff, pend_in;
   logic [AW-1:0]            rd_addr_ff, rd_addr_in;
   logic [WORD_W-1:0]        acc_ff, acc_in;
   logic                     strobe_ff, strobe_in;
   logic [WORD_W-1:0]        word_ff, word_in;
   logic [FOUND_W-1:0]       at_ff, at_in;
   status_type               status_ff, status_in;
   logic [FILL_OUT_W-1:0]    fill_out_ff, fill_out_in;

   logic                     wr_en, rd_en;
   logic [AW-1:0]            wr_addr, rd_addr;
   logic [WORD_W-1:0]        wr_data, ram_q, data;
   logic [EXT_W-1:0]         pos_x;
   logic                     pos_ok;
   logic [AW-1:0]            pos_addr;
   logic [FW-1:0]            cur;
   logic [EXT_W-1:0]         fill_x, at_x;

   bvte_ram #(
      .WIDTH (WORD_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   assign pos_x    = EXT_W'(head.item.pos);
   assign pos_ok   = pos_x < EXT_W'(fill_ff);
   assign pos_addr = pos_x[AW-1:0];
   assign cur      = (cursor_ff >= fill_ff) ? '0 : cursor_ff;
   assign data     = (rd_addr_ff == '0 && !e0_valid_ff) ? '0 : ram_q;
   assign fill_x   = EXT_W'(fill_in);
   assign at_x     = EXT_W'(rd_addr_ff);

   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      cursor_in   = cursor_ff;
      e0_valid_in = e0_valid_ff;
      op_in       = op_ff;
      key_in      = key_ff;
      issue_in    = issue_ff;
      pend_in     = 1'b0;
      rd_addr_in  = rd_addr_ff;
      acc_in      = acc_ff;
      wr_en       = 1'b0;
      wr_addr     = '0;
      wr_data     = '0;
      rd_en       = 1'b0;
      rd_addr     = '0;
      pop         = 1'b0;
      strobe_in   = 1'b0;
      word_in     = '0;
      at_in       = '0;
      status_in   = ST_OK;
      case (state_ff)
         BK_IDLE: begin
            if (head.valid) begin
               pop = 1'b1;
               case (head.item.cmd)
                  CMD_INIT: begin
                     wr_en       = 1'b1;
                     wr_data     = head.item.word;
                     fill_in     = FW'(1);
                     cursor_in   = '0;
                     e0_valid_in = 1'b1;
                     strobe_in   = 1'b1;
                  end
                  CMD_PUSH: begin
                     if (fill_ff < CAP_F) begin
                        wr_en   = 1'b1;
                        wr_addr = fill_ff[AW-1:0];
                        wr_data = head.item.word;
                        fill_in = fill_ff + 1'b1;
                     end else begin
                        status_in = ST_FULL;
                     end
                     strobe_in = 1'b1;
                  end
                  CMD_GET: begin
                     if (pos_ok) begin
                        rd_en      = 1'b1;
                        rd_addr    = pos_addr;
                        rd_addr_in = pos_addr;
                        state_in   = BK_READ;
                     end else begin
                        word_in   = '1;
                        status_in = ST_MISS;
                        strobe_in = 1'b1;
                     end
                  end
                  CMD_SET: begin
                     if (pos_ok) begin
                        wr_en   = 1'b1;
                        wr_addr = pos_addr;
                        wr_data = head.item.word;
                        if (pos_addr == '0) begin
                           e0_valid_in = 1'b1;
                        end
                     end else begin
                        status_in = ST_MISS;
                     end
                     strobe_in = 1'b1;
                  end
                  CMD_NEXT: begin
                     rd_en      = 1'b1;
                     rd_addr    = cur[AW-1:0];
                     rd_addr_in = cur[AW-1:0];
                     cursor_in  = cur + 1'b1;
                     state_in   = BK_READ;
                  end
                  CMD_FIND, CMD_SUM: begin
                     op_in      = head.item.cmd;
                     key_in     = head.item.word;
                     acc_in     = '0;
                     rd_en      = 1'b1;
                     rd_addr    = '0;
                     rd_addr_in = '0;
                     issue_in   = FW'(1);
                     pend_in    = 1'b1;
                     state_in   = BK_SCAN;
                  end
                  CMD_REWIND: begin
                     cursor_in = '0;
                     strobe_in = 1'b1;
                  end
                  default: begin
                     strobe_in = 1'b1;
                  end
               endcase
            end
         end
         BK_READ: begin
            word_in   = data;
            strobe_in = 1'b1;
            state_in  = BK_IDLE;
         end
         BK_SCAN: begin
            if (pend_ff && op_ff == CMD_FIND && data == key_ff) begin
               at_in     = at_x[FOUND_W-1:0];
               strobe_in = 1'b1;
               state_in  = BK_IDLE;
            end else begin
               if (pend_ff) begin
                  acc_in = acc_ff + data;
               end
               if (issue_ff < fill_ff) begin
                  rd_en      = 1'b1;
                  rd_addr    = issue_ff[AW-1:0];
                  rd_addr_in = issue_ff[AW-1:0];
                  issue_in   = issue_ff + 1'b1;
                  pend_in    = 1'b1;
               end else if (!pend_ff) begin
                  if (op_ff == CMD_FIND) begin
                     status_in = ST_MISS;
                  end else begin
                     word_in = acc_ff;
                  end
                  strobe_in = 1'b1;
                  state_in  = BK_IDLE;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
      fill_out_in = fill_x[FILL_OUT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= BK_IDLE;
         fill_ff     <= FW'(1);
         cursor_ff   <= '0;
         e0_valid_ff <= 1'b0;
         pend_ff     <= 1'b0;
         strobe_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         fill_ff     <= fill_in;
         cursor_ff   <= cursor_in;
         e0_valid_ff <= e0_valid_in;
         pend_ff     <= pend_in;
         strobe_ff   <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      issue_ff    <= issue_in;
      rd_addr_ff  <= rd_addr_in;
      acc_ff      <= acc_in;
      word_ff     <= word_in;
      at_ff       <= at_in;
      status_ff   <= status_in;
      fill_out_ff <= fill_out_in;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_read_word = word_ff;
   assign rsp_found_at  = at_ff;
   assign rsp_status    = status_ff;
   assign rsp_fill      = fill_out_ff;

`ifndef SYNTHESIS
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff != '0 && fill_ff <= CAP_F)
      else $error("fill count out of range");
   a_cursor_bound: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= fill_ff)
      else $error("cursor beyond fill count");
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_SCAN |-> issue_ff <= fill_ff && issue_ff != '0)
      else $error("scan index beyond fill count");
`endif

endmodule

FILE: hw/rtl/bounded_vector_table_engine.sv
// Init, push, set and rewind are executed from the idle state and give a registered result.
// Get and next pass through a read state, bounded by the registered read of the entry store.
// Find and sum walk the store one entry a cycle.
// The back end takes one init, push, set or rewind a cycle while the queue holds commands;
// a get, next, find or sum holds it until its result is formed. A two-deep queue feeds it.
// Synchronous reset empties the queue and sets fill to one, cursor and entry zero to zero.
module bounded_vector_table_engine
   import bvte_pkg::*;
#(
   parameter int CAPACITY = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [2:0]                   req_command,
   input  logic [POS_W-1:0]             req_position,
   input  logic signed [WORD_W-1:0]     req_word,
   output logic                         rsp_strobe,
   output logic signed [WORD_W-1:0]     rsp_read_word,
   output logic [FOUND_W-1:0]           rsp_found_at,
   output logic [1:0]                   rsp_status,
   output logic [FILL_OUT_W-1:0]        rsp_fill
);

   queue_head_type head;
   logic           pop;

   bvte_front u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_command  (req_command),
      .req_position (req_position),
      .req_word     (req_word),
      .head         (head),
      .pop          (pop)
   );

   bvte_back #(
      .CAPACITY (CAPACITY)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .pop           (pop),
      .rsp_strobe    (rsp_strobe),
      .rsp_read_word (rsp_read_word),
      .rsp_found_at  (rsp_found_at),
      .rsp_status    (rsp_status),
      .rsp_fill      (rsp_fill)
   );

endmodule
